[rtl/sjb_pkg.sv]
// sjb_pkg: shared types and constants for the sequence reorder jitter buffer.
// Word structs, status codes, controller/datapath command and status groups.
// No dependencies.
package sjb_pkg;

    localparam logic [15:0] WRAP_HIGH = 16'hfc00;
    localparam logic [15:0] WRAP_LOW  = 16'h0400;

    localparam int NUM_REGS = 6;
    localparam int PADDR_W  = 5;

    typedef enum logic [2:0] {
        REG_VIDEO_CODE  = 3'd0,
        REG_AUDIO_CODE  = 3'd1,
        REG_VIDEO_WAIT  = 3'd2,
        REG_AUDIO_WAIT  = 3'd3,
        REG_OTHER_WAIT  = 3'd4,
        REG_LATE_CREDIT = 3'd5
    } sjb_reg_e;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_BAD_Q    = 3'd3,
        ST_RELEASED = 3'd4,
        ST_NONE     = 3'd5
    } sjb_status_e;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_FETCH  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  queue_id;
        logic [15:0] seq_num;
        logic [7:0]  pkt_handle;
        logic        no_wait;
        logic [31:0] now_ms;
    } sjb_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_handle;
        logic [15:0] out_seq;
    } sjb_out_t;

    typedef struct packed {
        logic [7:0]  video_type_code;
        logic [7:0]  audio_type_code;
        logic [15:0] video_wait_ms;
        logic [15:0] audio_wait_ms;
        logic [15:0] other_wait_ms;
        logic [15:0] late_credit_ms;
    } sjb_cfg_t;

    typedef struct packed {
        logic        load;
        logic        init;
        logic        step;
        logic        mark;
        logic        shift;
        logic        put;
        logic        pop;
        logic        out_load;
        sjb_status_e status;
    } sjb_cmd_t;

    typedef struct packed {
        logic bad;
        logic fetch;
        logic empty;
        logic full;
        logic stop;
        logic dup;
        logic idx_one;
        logic at_fill;
        logic shift_last;
        logic ready;
        logic out_free;
    } sjb_stat_t;

endpackage

[rtl/sjb_regs.sv]
// sjb_regs: APB-style configuration register file.
// Depends on sjb_pkg.
module sjb_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sjb_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output sjb_pkg::sjb_cfg_t              cfg
);
    import sjb_pkg::*;

    sjb_cfg_t cfg_reg;
    logic [2:0] idx;
    logic wr_en;

    assign idx   = paddr[PADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.video_type_code <= 8'd0;
            cfg_reg.audio_type_code <= 8'd1;
            cfg_reg.video_wait_ms   <= 16'd350;
            cfg_reg.audio_wait_ms   <= 16'd350;
            cfg_reg.other_wait_ms   <= 16'd50;
            cfg_reg.late_credit_ms  <= 16'd100;
        end else if (wr_en) begin
            case (idx)
                REG_VIDEO_CODE:  cfg_reg.video_type_code <= pwdata[7:0];
                REG_AUDIO_CODE:  cfg_reg.audio_type_code <= pwdata[7:0];
                REG_VIDEO_WAIT:  cfg_reg.video_wait_ms   <= pwdata[15:0];
                REG_AUDIO_WAIT:  cfg_reg.audio_wait_ms   <= pwdata[15:0];
                REG_OTHER_WAIT:  cfg_reg.other_wait_ms   <= pwdata[15:0];
                REG_LATE_CREDIT: cfg_reg.late_credit_ms  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_VIDEO_CODE:  prdata = {24'd0, cfg_reg.video_type_code};
            REG_AUDIO_CODE:  prdata = {24'd0, cfg_reg.audio_type_code};
            REG_VIDEO_WAIT:  prdata = {16'd0, cfg_reg.video_wait_ms};
            REG_AUDIO_WAIT:  prdata = {16'd0, cfg_reg.audio_wait_ms};
            REG_OTHER_WAIT:  prdata = {16'd0, cfg_reg.other_wait_ms};
            REG_LATE_CREDIT: prdata = {16'd0, cfg_reg.late_credit_ms};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

[rtl/sjb_ctrl.sv]
// sjb_ctrl: sequencing state machine for insert walk and head fetch.
// Depends on sjb_pkg; drives the datapath through sjb_cmd_t.
module sjb_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sjb_pkg::sjb_stat_t stat,
    output sjb_pkg::sjb_cmd_t  cmd
);
    import sjb_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_CHECK = 8'b00000010,
        S_READ  = 8'b00000100,
        S_CMP   = 8'b00001000,
        S_SRD   = 8'b00010000,
        S_SWR   = 8'b00100000,
        S_PUT   = 8'b01000000,
        S_FIN   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    sjb_status_e status_reg, status_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.init = 1'b1;
                if (stat.bad) begin
                    status_next = ST_BAD_Q;
                    state_next  = S_FIN;
                end else if (stat.fetch) begin
                    if (stat.empty) begin
                        status_next = ST_NONE;
                        state_next  = S_FIN;
                    end else begin
                        state_next = S_READ;
                    end
                end else if (stat.full) begin
                    status_next = ST_FULL;
                    state_next  = S_FIN;
                end else if (stat.empty) begin
                    state_next = S_PUT;
                end else begin
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_CMP;
            S_CMP: begin
                if (stat.fetch) begin
                    state_next = S_FIN;
                    if (stat.ready) begin
                        cmd.pop     = 1'b1;
                        status_next = ST_RELEASED;
                    end else begin
                        status_next = ST_NONE;
                    end
                end else if (stat.stop) begin
                    cmd.mark   = 1'b1;
                    state_next = stat.at_fill ? S_PUT : S_SRD;
                end else if (stat.dup) begin
                    status_next = ST_DUP;
                    state_next  = S_FIN;
                end else begin
                    cmd.step = 1'b1;
                    if (stat.idx_one) begin
                        cmd.mark   = 1'b1;
                        state_next = S_SRD;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_SRD: state_next = S_SWR;
            S_SWR: begin
                cmd.shift  = 1'b1;
                state_next = stat.shift_last ? S_PUT : S_SRD;
            end
            S_PUT: begin
                cmd.put     = 1'b1;
                status_next = ST_INSERTED;
                state_next  = S_FIN;
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_INSERTED;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

[rtl/sjb_dpath.sv]
// sjb_dpath: entry memory, per-queue head/fill counters, item and output registers.
// Depends on sjb_pkg; commanded by sjb_ctrl.
module sjb_dpath #(
    parameter int QUEUES       = 4,
    parameter int DEPTH        = 16,
    parameter int HANDLE_WIDTH = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  sjb_pkg::sjb_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sjb_pkg::sjb_out_t  m_data,
    input  sjb_pkg::sjb_cfg_t  cfg,
    input  sjb_pkg::sjb_cmd_t  cmd,
    output sjb_pkg::sjb_stat_t stat
);
    import sjb_pkg::*;

    localparam int QW    = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int SW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(QUEUES * DEPTH);
    localparam int WORDS = QUEUES * DEPTH;

    typedef struct packed {
        logic [15:0]             seq;
        logic [HANDLE_WIDTH-1:0] handle;
        logic [31:0]             t;
        logic                    nw;
    } entry_t;

    entry_t mem [WORDS];
    entry_t rdata_reg;

    logic [CW-1:0] fill_reg [QUEUES];
    logic [SW-1:0] head_reg [QUEUES];

    logic                    req_reg;
    logic                    bad_reg;
    logic [7:0]              qid_reg;
    logic [QW-1:0]           q_reg;
    logic [15:0]             seq_reg;
    logic [HANDLE_WIDTH-1:0] handle_reg;
    logic                    nw_reg;
    logic [31:0]             t_reg;
    logic [CW-1:0]           idx_reg;
    logic [CW-1:0]           pos_reg;
    logic [15:0]             rel_seq_reg;
    logic [HANDLE_WIDTH-1:0] rel_handle_reg;
    logic                    out_valid_reg;
    sjb_out_t                out_reg;

    logic [CW-1:0] fill_cur;
    logic [SW-1:0] head_cur;
    logic [CW-1:0] rd_log;
    logic [CW:0]   rd_sum;
    logic [CW:0]   wr_sum;
    logic [SW-1:0] rd_phys;
    logic [SW-1:0] wr_phys;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wait_ms;
    logic [31:0]   age;
    logic [SW:0]   head_inc;
    logic          out_free;
    entry_t        new_entry;

    assign fill_cur = fill_reg[q_reg];
    assign head_cur = head_reg[q_reg];

    assign rd_log  = (req_reg == REQ_FETCH) ? '0 : idx_reg - CW'(1);
    assign rd_sum  = (CW + 1)'(head_cur) + (CW + 1)'(rd_log);
    assign wr_sum  = (CW + 1)'(head_cur) + (CW + 1)'(idx_reg);
    assign rd_phys = (rd_sum >= (CW + 1)'(DEPTH)) ? SW'(rd_sum - (CW + 1)'(DEPTH)) : SW'(rd_sum);
    assign wr_phys = (wr_sum >= (CW + 1)'(DEPTH)) ? SW'(wr_sum - (CW + 1)'(DEPTH)) : SW'(wr_sum);
    assign rd_addr = AW'(int'(q_reg) * DEPTH + int'(rd_phys));
    assign wr_addr = AW'(int'(q_reg) * DEPTH + int'(wr_phys));

    assign head_inc = (SW + 1)'(head_cur) + (SW + 1)'(1);

    always_comb begin
        if (qid_reg == cfg.video_type_code)
            wait_ms = cfg.video_wait_ms;
        else if (qid_reg == cfg.audio_type_code)
            wait_ms = cfg.audio_wait_ms;
        else
            wait_ms = cfg.other_wait_ms;
    end

    assign age = t_reg - rdata_reg.t;

    assign new_entry.seq    = seq_reg;
    assign new_entry.handle = handle_reg;
    assign new_entry.t      = t_reg;
    assign new_entry.nw     = nw_reg;

    assign out_free = !out_valid_reg || m_ready;

    assign stat.bad        = bad_reg;
    assign stat.fetch      = (req_reg == REQ_FETCH);
    assign stat.empty      = (fill_cur == '0);
    assign stat.full       = (fill_cur == CW'(DEPTH));
    assign stat.stop       = (rdata_reg.seq < seq_reg)
                          || ((rdata_reg.seq > WRAP_HIGH) && (seq_reg < WRAP_LOW));
    assign stat.dup        = (rdata_reg.seq == seq_reg);
    assign stat.idx_one    = (idx_reg == CW'(1));
    assign stat.at_fill    = (idx_reg == fill_cur);
    assign stat.shift_last = (idx_reg == pos_reg + CW'(1));
    assign stat.ready      = rdata_reg.nw || (age >= {16'd0, wait_ms});
    assign stat.out_free   = out_free;

    // walk compares only; entries move up one slot in a second pass once the slot is known
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[rd_addr];
        if (cmd.shift)
            mem[wr_addr] <= rdata_reg;
        else if (cmd.put)
            mem[wr_addr] <= new_entry;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg    <= s_data.req_type;
            qid_reg    <= s_data.queue_id;
            q_reg      <= QW'(s_data.queue_id);
            bad_reg    <= ({1'b0, s_data.queue_id} >= 9'(QUEUES));
            seq_reg    <= s_data.seq_num;
            handle_reg <= HANDLE_WIDTH'(s_data.pkt_handle);
            nw_reg     <= s_data.no_wait;
            t_reg      <= s_data.now_ms;
        end else if (cmd.step) begin
            t_reg <= (t_reg > {16'd0, cfg.late_credit_ms})
                   ? t_reg - {16'd0, cfg.late_credit_ms} : 32'd0;
        end
        if (cmd.init || cmd.mark)
            idx_reg <= fill_cur;
        else if (cmd.step || cmd.shift)
            idx_reg <= idx_reg - CW'(1);
        if (cmd.mark)
            pos_reg <= stat.stop ? idx_reg : '0;
        if (cmd.pop) begin
            rel_seq_reg    <= rdata_reg.seq;
            rel_handle_reg <= rdata_reg.handle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < QUEUES; i++) begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
            end
        end else if (cmd.put) begin
            fill_reg[q_reg] <= fill_cur + CW'(1);
        end else if (cmd.pop) begin
            fill_reg[q_reg] <= fill_cur - CW'(1);
            head_reg[q_reg] <= (head_inc >= (SW + 1)'(DEPTH)) ? '0 : SW'(head_inc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.status <= cmd.status;
            if (cmd.status == ST_RELEASED) begin
                out_reg.out_handle <= 8'(rel_handle_reg);
                out_reg.out_seq    <= rel_seq_reg;
            end else begin
                out_reg.out_handle <= 8'd0;
                out_reg.out_seq    <= 16'd0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

[rtl/seq_reorder_jitter_buffer.sv]
// seq_reorder_jitter_buffer: per-stream sequence-sorted reorder buffer, top level.
// Depends on sjb_pkg, sjb_regs, sjb_ctrl, sjb_dpath.
//
//   channel | ports                         | word / access
//   --------+-------------------------------+-----------------------------
//   input   | s_valid s_ready s_data        | sjb_in_t, insert or fetch
//   result  | m_valid m_ready m_data        | sjb_out_t, one per input word
//   config  | psel penable pwrite paddr ... | 6 registers at 4*index
//
// One word in flight. Bad queue, full, or fetch on empty go from the check state to
// the final state; insert into empty goes to put; fetch reads and tests the head.
// Insert walks from the tail (read, compare), then shifts passed entries up a slot
// (read, write) and puts the new one. Reset clears queue counters, state and config;
// entry memory needs no clearing. A stalled result holds; the next word is taken
// meanwhile and waits in the final state until the result register frees.
module seq_reorder_jitter_buffer #(
    parameter int QUEUES       = 4,
    parameter int DEPTH        = 16,
    parameter int HANDLE_WIDTH = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  sjb_pkg::sjb_in_t            s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output sjb_pkg::sjb_out_t           m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sjb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import sjb_pkg::*;

    sjb_cfg_t  cfg;
    sjb_cmd_t  cmd;
    sjb_stat_t stat;

    assign pready = 1'b1;

    sjb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    sjb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sjb_dpath #(
        .QUEUES       (QUEUES),
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cfg     (cfg),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

[rtl/sjb_checker.sv]
// sjb_checker: port-level assertions for seq_reorder_jitter_buffer, with bind.
// Depends on sjb_pkg and the top level.
module sjb_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input sjb_pkg::sjb_out_t m_data
);
    import sjb_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status <= ST_NONE))
        else $error("status out of range");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_RELEASED)
        |-> (m_data.out_handle == 8'd0) && (m_data.out_seq == 16'd0))
        else $error("nonzero packet fields without release");

    a_one_at_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while busy");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind seq_reorder_jitter_buffer sjb_checker u_sjb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[verif/tb_seq_reorder_jitter_buffer.sv]
// Testbench for seq_reorder_jitter_buffer: random and directed insert/fetch words
// checked against a behavioral model of the per-stream reorder queues.
// Depends on sjb_pkg and the seq_reorder_jitter_buffer RTL.
`timescale 1ns / 1ps

module tb_seq_reorder_jitter_buffer;
    import sjb_pkg::*;

    localparam int QUEUES = 4;
    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    sjb_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    sjb_out_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    seq_reorder_jitter_buffer dut (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    // behavioral copy of the queues and registers
    logic [7:0] m_video_code, m_audio_code;
    logic [15:0] m_video_wait, m_audio_wait, m_other_wait, m_credit;
    logic [15:0] q_seq [QUEUES][DEPTH];
    logic [7:0] q_hdl [QUEUES][DEPTH];
    logic [31:0] q_time [QUEUES][DEPTH];
    logic q_nw [QUEUES][DEPTH];
    int q_fill [QUEUES];
    logic [31:0] now_clock;

    sjb_in_t pending_words[$];
    sjb_out_t expected_results[$];
    int errors = 0;
    int cycles = 0;
    bit hold_off = 1'b0;
    int hold_count = 0;
    bit stim_done = 1'b0;

    function automatic sjb_out_t predict_word(sjb_in_t w);
        sjb_out_t r;
        int q, fill, pos, i;
        logic [31:0] t;
        logic [15:0] wait_ms;
        r = '0;
        q = w.queue_id;
        if (w.queue_id >= QUEUES) begin
            r.status = ST_BAD_Q;
            return r;
        end
        fill = q_fill[q];
        if (w.req_type == REQ_INSERT) begin
            if (fill >= DEPTH) begin
                r.status = ST_FULL;
                return r;
            end
            pos = 0;
            t = w.now_ms;
            for (i = fill; i > 0; i--) begin
                if (q_seq[q][i-1] < w.seq_num ||
                        (q_seq[q][i-1] > WRAP_HIGH && w.seq_num < WRAP_LOW)) begin
                    pos = i;
                    break;
                end
                if (q_seq[q][i-1] == w.seq_num) begin
                    r.status = ST_DUP;
                    return r;
                end
                t = (t > m_credit) ? t - m_credit : 32'd0;
            end
            for (i = fill; i > pos; i--) begin
                q_seq[q][i] = q_seq[q][i-1];
                q_hdl[q][i] = q_hdl[q][i-1];
                q_time[q][i] = q_time[q][i-1];
                q_nw[q][i] = q_nw[q][i-1];
            end
            q_seq[q][pos] = w.seq_num;
            q_hdl[q][pos] = w.pkt_handle;
            q_time[q][pos] = t;
            q_nw[q][pos] = w.no_wait;
            q_fill[q] = fill + 1;
            r.status = ST_INSERTED;
            return r;
        end
        if (fill == 0) begin
            r.status = ST_NONE;
            return r;
        end
        if (w.queue_id == m_video_code) wait_ms = m_video_wait;
        else if (w.queue_id == m_audio_code) wait_ms = m_audio_wait;
        else wait_ms = m_other_wait;
        if (q_nw[q][0] || (w.now_ms - q_time[q][0]) >= {16'd0, wait_ms}) begin
            r.status = ST_RELEASED;
            r.out_handle = q_hdl[q][0];
            r.out_seq = q_seq[q][0];
            for (i = 1; i < fill; i++) begin
                q_seq[q][i-1] = q_seq[q][i];
                q_hdl[q][i-1] = q_hdl[q][i];
                q_time[q][i-1] = q_time[q][i];
                q_nw[q][i-1] = q_nw[q][i];
            end
            q_fill[q] = fill - 1;
        end else begin
            r.status = ST_NONE;
        end
        return r;
    endfunction

    // driver: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    s_data <= pending_words.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_word(s_data));
        end
    end

    // receiver stall pattern and long hold-off
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            m_ready <= 1'b0;
        end else if (hold_off) begin
            hold_count <= 600;
            hold_off <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= (cycles % 64 < 32) ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    // monitor
    always @(posedge aclk) begin
        sjb_out_t e;
        int n;
        n = 0;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected: %h", m_data);
                n = n + 1;
            end else begin
                e = expected_results.pop_front();
                if (m_data.status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, m_data.status);
                    n = n + 1;
                end
                if (m_data.out_handle !== e.out_handle) begin
                    $error("out_handle expected %0d actual %0d", e.out_handle,
                        m_data.out_handle);
                    n = n + 1;
                end
                if (m_data.out_seq !== e.out_seq) begin
                    $error("out_seq expected %0d actual %0d", e.out_seq, m_data.out_seq);
                    n = n + 1;
                end
            end
            errors <= errors + n;
        end
    end

    always @(posedge aclk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic reg_write(sjb_reg_e idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_VIDEO_CODE: m_video_code = value[7:0];
            REG_AUDIO_CODE: m_audio_code = value[7:0];
            REG_VIDEO_WAIT: m_video_wait = value[15:0];
            REG_AUDIO_WAIT: m_audio_wait = value[15:0];
            REG_OTHER_WAIT: m_other_wait = value[15:0];
            REG_LATE_CREDIT: m_credit = value[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (4 * DEPTH + 8) @(posedge aclk);
    endtask

    function automatic sjb_in_t make_word(logic req, logic [7:0] q, logic [15:0] sq,
            logic [7:0] h, logic nw, logic [31:0] t);
        sjb_in_t w;
        w.req_type = req;
        w.queue_id = q;
        w.seq_num = sq;
        w.pkt_handle = h;
        w.no_wait = nw;
        w.now_ms = t;
        return w;
    endfunction

    task automatic add_stream_run(int n);
        int k;
        logic [7:0] q;
        logic [15:0] base;
        for (k = 0; k < n; k++) begin
            now_clock = now_clock + $urandom_range(0, 60);
            if ($urandom_range(0, 19) == 0) begin
                pending_words.push_back(make_word(1'($urandom_range(0, 1)),
                    8'($urandom_range(0, 255)), 16'($urandom), 8'($urandom),
                    1'($urandom_range(0, 1)), $urandom));
            end else begin
                q = 8'($urandom_range(0, QUEUES - 1));
                base = ($urandom_range(0, 3) == 0) ? 16'hfff0 : 16'($urandom);
                if ($urandom_range(0, 1)) begin
                    pending_words.push_back(make_word(REQ_INSERT, q,
                        base + 16'($urandom_range(0, 40)), 8'($urandom),
                        $urandom_range(0, 5) == 0, now_clock));
                end else begin
                    pending_words.push_back(make_word(REQ_FETCH, q, 16'($urandom),
                        8'($urandom), 1'($urandom_range(0, 1)),
                        ($urandom_range(0, 30) == 0) ? $urandom : now_clock));
                end
            end
        end
    endtask

    initial begin
        int i;
        m_video_code = 8'd0; m_audio_code = 8'd1;
        m_video_wait = 16'd350; m_audio_wait = 16'd350;
        m_other_wait = 16'd50; m_credit = 16'd100;
        for (i = 0; i < QUEUES; i++) q_fill[i] = 0;
        now_clock = 32'd1000;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: wrap, duplicate, saturation, bad queue, empty, full, time wrap
        pending_words.push_back(make_word(REQ_FETCH, 8'd2, 16'd0, 8'd0, 1'b0, 32'd5));
        pending_words.push_back(make_word(REQ_INSERT, 8'd255, 16'hffff, 8'hff, 1'b1,
            32'hffffffff));
        pending_words.push_back(make_word(REQ_FETCH, 8'd4, 16'd0, 8'd0, 1'b0, 32'd0));
        pending_words.push_back(make_word(REQ_INSERT, 8'd0, 16'hfffe, 8'h11, 1'b0, 32'd50));
        pending_words.push_back(make_word(REQ_INSERT, 8'd0, 16'h0001, 8'h22, 1'b0, 32'd60));
        pending_words.push_back(make_word(REQ_INSERT, 8'd0, 16'hfffe, 8'h33, 1'b0, 32'd70));
        pending_words.push_back(make_word(REQ_INSERT, 8'd0, 16'hfff0, 8'h44, 1'b0, 32'd80));
        pending_words.push_back(make_word(REQ_FETCH, 8'd0, 16'd0, 8'd0, 1'b0, 32'd100));
        pending_words.push_back(make_word(REQ_FETCH, 8'd0, 16'd0, 8'd0, 1'b0, 32'hfffffff0));
        pending_words.push_back(make_word(REQ_INSERT, 8'd3, 16'd9, 8'h00, 1'b1, 32'd0));
        pending_words.push_back(make_word(REQ_FETCH, 8'd3, 16'd0, 8'd0, 1'b0, 32'd0));
        for (i = 0; i < DEPTH + 1; i++)
            pending_words.push_back(make_word(REQ_INSERT, 8'd1, 16'(100 - i), 8'(i),
                1'b0, 32'd500));
        wait_drained();
        for (i = 0; i < DEPTH; i++)
            pending_words.push_back(make_word(REQ_FETCH, 8'd1, 16'd0, 8'd0, 1'b0,
                32'hffffffff));
        wait_drained();

        reg_write(REG_VIDEO_CODE, 32'd2);
        reg_write(REG_AUDIO_CODE, 32'd255);
        reg_write(REG_VIDEO_WAIT, 32'hffff);
        reg_write(REG_AUDIO_WAIT, 32'd0);
        reg_write(REG_OTHER_WAIT, 32'd0);
        reg_write(REG_LATE_CREDIT, 32'hffff);
        add_stream_run(250);
        @(posedge aclk);
        hold_off <= 1'b1;
        wait_drained();

        reg_write(REG_VIDEO_CODE, 32'd255);
        reg_write(REG_AUDIO_CODE, 32'd3);
        reg_write(REG_VIDEO_WAIT, 32'd0);
        reg_write(REG_AUDIO_WAIT, 32'hffff);
        reg_write(REG_OTHER_WAIT, 32'd40);
        reg_write(REG_LATE_CREDIT, 32'd0);
        add_stream_run(250);
        wait_drained();

        reg_write(REG_VIDEO_CODE, 32'd1);
        reg_write(REG_AUDIO_CODE, 32'd0);
        reg_write(REG_VIDEO_WAIT, 32'd120);
        reg_write(REG_AUDIO_WAIT, 32'd200);
        reg_write(REG_OTHER_WAIT, 32'hffff);
        reg_write(REG_LATE_CREDIT, 32'd30);
        add_stream_run(300);
        wait_drained();

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/sjb_pkg.sv
rtl/sjb_regs.sv
rtl/sjb_ctrl.sv
rtl/sjb_dpath.sv
rtl/seq_reorder_jitter_buffer.sv
rtl/sjb_checker.sv
verif/tb_seq_reorder_jitter_buffer.sv
